// ===== src/scf_pkg.sv =====
// scf_pkg: types, codes and the per-cell byte function of the command framer
// used by the channel interfaces, the check stage, the byte cells and the top level
`default_nettype none

package scf_pkg;

  localparam int unsigned FRAME_BYTES_DEF = 16;
  localparam int unsigned FRAME_W  = 20;
  localparam int unsigned WORD_W   = 8;
  localparam int unsigned BIT_W    = 8;
  localparam int unsigned CMD_W    = 3;
  localparam int unsigned ERR_W    = 2;
  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned CFG_W    = 20;
  localparam int unsigned REG_IDX_W = 1;

  localparam int unsigned PREFIX_LEN  = 5;
  localparam int unsigned HEX_DIGITS  = 8;
  localparam int unsigned FRAME_SHIFT = 12;
  localparam int unsigned WORD_SHIFT  = 5;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_FRAME_LIMIT = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_LAST_WORD   = 1'b1;

  localparam logic [CFG_W-1:0]  FRAME_LIMIT_RST = 20'd57532;
  localparam logic [WORD_W-1:0] LAST_WORD_RST   = 8'd92;
  localparam logic [BIT_W-1:0]  BIT_LIMIT       = 8'd31;

  // lower frame bound of the reset limit
  localparam logic [CFG_W:0]    FRAME_LOW_RST = (CFG_W+1)'(FRAME_LIMIT_RST / 3 * 2);

  // ceil(2^21/3): exact x/3 for any 20-bit x
  localparam logic [CFG_W:0]    DIV3_MUL   = 21'd699051;
  localparam int unsigned       DIV3_SHIFT = 21;

  // command codes
  localparam logic [CMD_W-1:0] CMD_IDLE   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_OBSERV = 3'd1;
  localparam logic [CMD_W-1:0] CMD_DETECT = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DIAG   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_INJECT = 3'd5;

  // error codes
  localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
  localparam logic [ERR_W-1:0] ERR_FRAME = 2'd1;
  localparam logic [ERR_W-1:0] ERR_WORD  = 2'd2;
  localparam logic [ERR_W-1:0] ERR_BIT   = 2'd3;

  // ascii
  localparam logic [7:0] CH_I     = 8'h49;
  localparam logic [7:0] CH_O     = 8'h4F;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_U     = 8'h55;
  localparam logic [7:0] CH_Q     = 8'h51;
  localparam logic [7:0] CH_N     = 8'h4E;
  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ALPHA = 8'h37;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [ERR_W-1:0]  err;
    logic [ADDR_W-1:0] addr;
  } load_t;

  typedef struct packed {
    logic              valid;
    logic              last;
    logic [7:0]        data;
    logic [ERR_W-1:0]  err;
  } cell_t;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctrl_t;

  function automatic logic [7:0] hex_char(logic [3:0] nib);
    logic [7:0] base;
    base = (nib < 4'd10) ? CH_ZERO : CH_ALPHA;
    return base + {4'b0, nib};
  endfunction

  // contents of cell idx of an nbytes frame for one command
  function automatic cell_t cell_load(int idx, int nbytes, load_t ld);
    cell_t       c;
    logic [31:0] sh;
    c  = '0;
    sh = '0;
    if (ld.err != ERR_NONE) begin
      // error result: a single beat at the head
      c.valid = (idx == 0);
      c.last  = 1'b1;
      c.err   = ld.err;
    end else begin
      c.valid = 1'b1;
      c.last  = (idx == nbytes - 1);
      if (ld.cmd == CMD_QUERY || ld.cmd == CMD_INJECT) begin
        if (idx == 0) begin
          c.data = (ld.cmd == CMD_QUERY) ? CH_Q : CH_N;
        end else if (idx == 1) begin
          c.data = CH_SPACE;
        end else if (idx == 2) begin
          c.data = CH_C;
        end else if (idx == 3 || idx == 4) begin
          c.data = CH_ZERO;
        end else if (idx < int'(PREFIX_LEN + HEX_DIGITS)) begin
          // hex digits, most significant first
          sh = ld.addr >> (4 * (int'(PREFIX_LEN + HEX_DIGITS) - 1 - idx));
          c.data = hex_char(sh[3:0]);
        end
      end else if (idx == 0) begin
        unique case (ld.cmd)
          CMD_OBSERV: c.data = CH_O;
          CMD_DETECT: c.data = CH_D;
          CMD_DIAG:   c.data = CH_U;
          default:    c.data = CH_I;
        endcase
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== src/scf_if.sv =====
// scf_if: valid/ready channel interfaces of the command framer
// depends on scf_pkg for the field widths
`default_nettype none

interface scf_cmd_if;
  logic                           valid;
  logic                           ready;
  logic [scf_pkg::CMD_W-1:0]      command;
  logic [scf_pkg::FRAME_W-1:0]    frame_addr;
  logic [scf_pkg::WORD_W-1:0]     word_addr;
  logic [scf_pkg::BIT_W-1:0]      bit_addr;

  modport source (output valid, command, frame_addr, word_addr, bit_addr, input ready);
  modport sink   (input valid, command, frame_addr, word_addr, bit_addr, output ready);
endinterface

interface scf_res_if;
  logic                        valid;
  logic                        ready;
  logic [7:0]                  out_byte;
  logic                        last;
  logic [scf_pkg::ERR_W-1:0]   error;

  modport source (output valid, out_byte, last, error, input ready);
  modport sink   (input valid, out_byte, last, error, output ready);
endinterface

`default_nettype wire

// ===== src/scf_cell.sv =====
// scf_cell: one byte cell of the output chain, parallel load or shift from its neighbor
// depends on scf_pkg (cell_t, load_t, cell_load)
`default_nettype none

module scf_cell #(
  parameter int IDX    = 0,
  parameter int NBYTES = 16
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  scf_pkg::cell_ctrl_t ctrl_i,
  input  scf_pkg::load_t      ld_i,
  input  scf_pkg::cell_t      nbr_i,
  output scf_pkg::cell_t      cell_o
);
  import scf_pkg::*;

  cell_t cell_d, cell_q;

  always_comb begin
    priority if (ctrl_i.load) begin
      cell_d = cell_load(IDX, NBYTES, ld_i);
    end else if (ctrl_i.shift) begin
      cell_d = nbr_i;
    end else begin
      cell_d = cell_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

`default_nettype wire

// ===== src/scf_check.sv =====
// scf_check: config registers, frame bound, command holding stage and range checks
// depends on scf_pkg (codes, load_t)
`default_nettype none

module scf_check (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             cfg_we_i,
  input  wire [scf_pkg::REG_IDX_W-1:0]    cfg_idx_i,
  input  wire [scf_pkg::CFG_W-1:0]        cfg_wdata_i,
  input  wire                             in_fire_i,
  input  wire [scf_pkg::CMD_W-1:0]        command_i,
  input  wire [scf_pkg::FRAME_W-1:0]      frame_addr_i,
  input  wire [scf_pkg::WORD_W-1:0]       word_addr_i,
  input  wire [scf_pkg::BIT_W-1:0]        bit_addr_i,
  input  wire                             take_i,
  output logic                            valid_o,
  output scf_pkg::load_t                  ld_o
);
  import scf_pkg::*;

  logic [CFG_W-1:0]     limit_q;
  logic [CFG_W-1:0]     limit_d;
  logic [WORD_W-1:0]    last_word_q;
  logic [CFG_W:0]       low_d, low_q;
  logic [2*CFG_W:0]     prod;

  logic                 a_valid_d, a_valid_q;
  logic [CMD_W-1:0]     a_cmd_q;
  logic [FRAME_W-1:0]   a_lfa_q;
  logic [WORD_W-1:0]    a_wa_q;
  logic [BIT_W-1:0]     a_ba_q;

  logic                 frame_ok;
  logic [WORD_W-1:0]    wa_eff;
  logic [BIT_W-1:0]     ba_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q     <= FRAME_LIMIT_RST;
      last_word_q <= LAST_WORD_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_FRAME_LIMIT: limit_q     <= cfg_wdata_i;
        REG_LAST_WORD:   last_word_q <= cfg_wdata_i[WORD_W-1:0];
        default: ;
      endcase
    end
  end

  // lower frame bound (limit/3)*2, registered together with the limit
  assign limit_d = (cfg_we_i && cfg_idx_i == REG_FRAME_LIMIT) ? cfg_wdata_i : limit_q;
  assign prod    = {{CFG_W{1'b0}}, 1'b0, limit_d} * {{CFG_W{1'b0}}, DIV3_MUL};
  assign low_d   = {prod[DIV3_SHIFT +: CFG_W], 1'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q <= FRAME_LOW_RST;
    end else begin
      low_q <= low_d;
    end
  end

  assign a_valid_d = in_fire_i ? 1'b1 : (take_i ? 1'b0 : a_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else begin
      a_valid_q <= a_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire_i) begin
      a_cmd_q <= command_i;
      a_lfa_q <= frame_addr_i;
      a_wa_q  <= word_addr_i;
      a_ba_q  <= bit_addr_i;
    end
  end

  assign frame_ok = ({1'b0, a_lfa_q} > low_q) &&
                    (({1'b0, a_lfa_q} + 21'd1) < {1'b0, limit_q});

  assign wa_eff = (a_cmd_q == CMD_INJECT) ? a_wa_q : '0;
  assign ba_eff = (a_cmd_q == CMD_INJECT) ? a_ba_q : '0;

  always_comb begin
    ld_o.cmd  = a_cmd_q;
    ld_o.addr = {a_lfa_q, {FRAME_SHIFT{1'b0}}} |
                {{(ADDR_W-WORD_W-WORD_SHIFT){1'b0}}, wa_eff, {WORD_SHIFT{1'b0}}} |
                {{(ADDR_W-BIT_W){1'b0}}, ba_eff};
    priority if ((a_cmd_q == CMD_QUERY || a_cmd_q == CMD_INJECT) && !frame_ok) begin
      ld_o.err = ERR_FRAME;
    end else if (a_cmd_q == CMD_INJECT && a_wa_q > last_word_q) begin
      ld_o.err = ERR_WORD;
    end else if (a_cmd_q == CMD_INJECT && a_ba_q > BIT_LIMIT) begin
      ld_o.err = ERR_BIT;
    end else begin
      ld_o.err = ERR_NONE;
    end
  end

  assign valid_o = a_valid_q;

endmodule

`default_nettype wire

// ===== src/sem_command_framer.sv =====
// sem_command_framer: command request in, ascii command frame out, one byte per beat
// depends on scf_pkg, scf_if (channels), scf_check and scf_cell
//
//   port     dir  beat contents
//   cmd_i    in   command, frame_addr, word_addr, bit_addr
//   res_o    out  out_byte, last, error
//   cfg_*    in   write enable, register index, write data (no handshake)
//
// a frame leaves as FRAME_BYTES beats, one per cycle while res_o is ready, an error
// as a single beat; throughput is set by the byte-wide result port draining the chain
// of byte cells; a taken command is registered in a holding stage, then in the cells;
// the next command waits there and loads the chain in the cycle the last beat of the
// frame ahead leaves, so frames follow without gap; a stall on res_o freezes the
// chain; reset empties the chain and holding stage and restores both registers
`default_nettype none

module sem_command_framer #(
  parameter int FRAME_BYTES = scf_pkg::FRAME_BYTES_DEF
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  scf_cmd_if.sink                        cmd_i,
  scf_res_if.source                      res_o,
  input  wire                            cfg_we_i,
  input  wire [scf_pkg::REG_IDX_W-1:0]   cfg_idx_i,
  input  wire [scf_pkg::CFG_W-1:0]       cfg_wdata_i
);
  import scf_pkg::*;

  logic       in_fire, out_fire;
  logic       stage_valid, take, chain_free;
  load_t      ld;
  cell_ctrl_t ctrl;
  cell_t      cells [FRAME_BYTES+1];

  assign in_fire  = cmd_i.valid && cmd_i.ready;
  assign out_fire = res_o.valid && res_o.ready;

  // chain frees up when the head is empty or its last beat leaves now
  assign chain_free  = !cells[0].valid || (out_fire && cells[0].last);
  assign take        = stage_valid && chain_free;
  assign cmd_i.ready = !stage_valid || take;

  assign ctrl.load  = take;
  assign ctrl.shift = out_fire;

  scf_check u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_fire_i    (in_fire),
    .command_i    (cmd_i.command),
    .frame_addr_i (cmd_i.frame_addr),
    .word_addr_i  (cmd_i.word_addr),
    .bit_addr_i   (cmd_i.bit_addr),
    .take_i       (take),
    .valid_o      (stage_valid),
    .ld_o         (ld)
  );

  assign cells[FRAME_BYTES] = '0;

  for (genvar g = 0; g < FRAME_BYTES; g++) begin : g_cell
    scf_cell #(
      .IDX    (g),
      .NBYTES (FRAME_BYTES)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .ld_i   (ld),
      .nbr_i  (cells[g+1]),
      .cell_o (cells[g])
    );
  end

  assign res_o.valid    = cells[0].valid;
  assign res_o.out_byte = cells[0].data;
  assign res_o.last     = cells[0].last;
  assign res_o.error    = cells[0].err;

`ifndef ASSERT_OFF
  // an error beat always closes its result
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.error != ERR_NONE) |-> res_o.last)
    else $error("error beat without last");

  // a frame continues on the beat after a non-final one
  a_frame_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && !res_o.last) |=> res_o.valid)
    else $error("gap inside a frame");

  // a non-final head always has a follower in the next cell
  a_chain_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cells[0].valid && !cells[0].last) |-> cells[1].valid)
    else $error("chain broken behind head");

  // a final beat with nothing waiting leaves the output empty
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && res_o.last && !stage_valid) |=> !res_o.valid)
    else $error("beat after end of frame");
`endif

endmodule

`default_nettype wire

// ===== tb/scf_frame_checker.sv =====
// scf_frame_checker: watches the command and result channels of the command framer,
// predicts every frame beat from the accepted commands and compares it with the output
// depends on scf_pkg and the channel interfaces in scf_if
module scf_frame_checker (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  scf_cmd_if                            cmd_i,
  scf_res_if                            res_i,
  input  wire                           cfg_we_i,
  input  wire [scf_pkg::REG_IDX_W-1:0]  cfg_idx_i,
  input  wire [scf_pkg::CFG_W-1:0]      cfg_wdata_i,
  output int unsigned                   fail_count_o,
  output int unsigned                   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import scf_pkg::*;

  localparam int unsigned   NBYTES     = FRAME_BYTES_DEF;
  localparam int unsigned   MAX_SHOWN  = 10;
  localparam logic [31:0]   BIT_MAX    = 32'd31;
  localparam logic [7:0]    ASCII_0    = "0";
  localparam logic [7:0]    ASCII_A    = "A";

  typedef struct packed {
    logic [7:0]       data;
    logic             last;
    logic [ERR_W-1:0] err;
  } frame_beat_t;

  frame_beat_t        frame_beats_q[$];
  logic [CFG_W-1:0]   frame_limit;
  logic [WORD_W-1:0]  last_word;
  int unsigned        fail_cnt = 0;
  int unsigned        pend_cnt = 0;

  assign fail_count_o = fail_cnt;
  assign pending_o    = pend_cnt;

  function automatic logic [7:0] hex_digit(logic [3:0] nib);
    if (nib < 4'd10) begin
      return ASCII_0 + {4'b0, nib};
    end
    return ASCII_A + {4'b0, nib} - 8'd10;
  endfunction

  function automatic void predict_frame(logic [CMD_W-1:0] cmd, logic [FRAME_W-1:0] lfa,
                                        logic [WORD_W-1:0] wa, logic [BIT_W-1:0] ba);
    logic [7:0]       frame_text [NBYTES];
    logic [31:0]      lfa32;
    logic [31:0]      low;
    logic [31:0]      word32;
    logic [31:0]      bit32;
    logic [31:0]      addr;
    logic [ERR_W-1:0] err;
    frame_beat_t      beat;
    for (int k = 0; k < NBYTES; k++) begin
      frame_text[k] = 8'h00;
    end
    err    = ERR_NONE;
    lfa32  = {12'b0, lfa};
    word32 = {24'b0, wa};
    bit32  = {24'b0, ba};
    if (cmd == CMD_QUERY || cmd == CMD_INJECT) begin
      low = {12'b0, frame_limit} / 32'd3 * 32'd2;
      if (!(lfa32 > low && lfa32 + 32'd1 < {12'b0, frame_limit})) begin
        err = ERR_FRAME;
      end else if (cmd == CMD_INJECT && wa > last_word) begin
        err = ERR_WORD;
      end else if (cmd == CMD_INJECT && bit32 > BIT_MAX) begin
        err = ERR_BIT;
      end
      // query always points at word 0, bit 0
      if (cmd == CMD_QUERY) begin
        word32 = '0;
        bit32  = '0;
      end
      addr = (lfa32 << FRAME_SHIFT) | (word32 << WORD_SHIFT) | bit32;
      frame_text[0] = (cmd == CMD_QUERY) ? "Q" : "N";
      frame_text[1] = " ";
      frame_text[2] = "C";
      frame_text[3] = "0";
      frame_text[4] = "0";
      for (int k = 0; k < 8; k++) begin
        frame_text[5 + k] = hex_digit(addr[4 * (7 - k) +: 4]);
      end
    end else begin
      case (cmd)
        CMD_OBSERV: frame_text[0] = "O";
        CMD_DETECT: frame_text[0] = "D";
        CMD_DIAG:   frame_text[0] = "U";
        default:    frame_text[0] = "I";
      endcase
    end
    if (err != ERR_NONE) begin
      beat = '{data: 8'h00, last: 1'b1, err: err};
      frame_beats_q.push_back(beat);
    end else begin
      for (int k = 0; k < NBYTES; k++) begin
        beat = '{data: frame_text[k], last: (k == NBYTES - 1), err: ERR_NONE};
        frame_beats_q.push_back(beat);
      end
    end
  endfunction

  always @(posedge clk_i) begin
    frame_beat_t want;
    if (!rst_ni) begin
      frame_limit = FRAME_LIMIT_RST;
      last_word   = LAST_WORD_RST;
      frame_beats_q.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_FRAME_LIMIT) begin
          frame_limit = cfg_wdata_i;
        end else if (cfg_idx_i == REG_LAST_WORD) begin
          last_word = cfg_wdata_i[WORD_W-1:0];
        end
      end
      if (res_i.valid && res_i.ready) begin
        if (frame_beats_q.size() == 0) begin
          if (fail_cnt < MAX_SHOWN) begin
            $display("unexpected beat: byte %02h last %0d err %0d",
                     res_i.out_byte, res_i.last, res_i.error);
          end
          fail_cnt++;
        end else begin
          want = frame_beats_q.pop_front();
          if (res_i.out_byte !== want.data || res_i.last !== want.last ||
              res_i.error !== want.err) begin
            if (fail_cnt < MAX_SHOWN) begin
              $display("beat mismatch: expected byte %02h last %0d err %0d,",
                       want.data, want.last, want.err,
                       " got byte %02h last %0d err %0d",
                       res_i.out_byte, res_i.last, res_i.error);
            end
            fail_cnt++;
          end
        end
      end
      if (cmd_i.valid && cmd_i.ready) begin
        predict_frame(cmd_i.command, cmd_i.frame_addr, cmd_i.word_addr, cmd_i.bit_addr);
      end
    end
    pend_cnt = frame_beats_q.size();
  end

endmodule

// ===== tb/tb_sem_command_framer.sv =====
// tb_sem_command_framer: drives command requests and register writes into the framer,
// stalls the result side at random and gives the verdict
// depends on scf_pkg, scf_if, sem_command_framer and scf_frame_checker
module tb_sem_command_framer;
  timeunit 1ns;
  timeprecision 1ps;
  import scf_pkg::*;

  localparam int unsigned CYCLE_LIMIT    = 1_000_000;
  localparam int unsigned HOLDOFF_CYCLES = 300;
  localparam int unsigned PHASES         = 6;
  localparam int unsigned PHASE_ITEMS    = 60;
  localparam logic [CMD_W-1:0] CMD_SPARE6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE7 = 3'd7;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [REG_IDX_W-1:0]  cfg_idx;
  logic [CFG_W-1:0]      cfg_wdata;
  int unsigned           fail_count;
  int unsigned           pending_beats;
  int unsigned           cycle_cnt = 0;
  int unsigned           cur_limit;
  int unsigned           cur_last_word;
  int unsigned           holdoff_req = 0;
  int unsigned           holdoff_done = 0;
  int unsigned           res_stall = 0;
  bit                    no_idle = 1'b0;

  scf_cmd_if cmd_if();
  scf_res_if res_if();

  sem_command_framer dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cmd_i       (cmd_if),
    .res_o       (res_if),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  scf_frame_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cmd_i        (cmd_if),
    .res_i        (res_if),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .fail_count_o (fail_count),
    .pending_o    (pending_beats)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // result side: random stall bursts, plus one long hold-off on request
  always @(posedge clk) begin
    if (holdoff_done != holdoff_req) begin
      holdoff_done++;
      res_stall = HOLDOFF_CYCLES;
    end
    if (res_stall > 0) begin
      res_stall--;
      res_if.ready <= 1'b0;
    end else if (!no_idle && $urandom_range(0, 15) == 0) begin
      res_stall = $urandom_range(1, 19) - 1;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  task automatic send_cmd(logic [CMD_W-1:0] cmd, logic [FRAME_W-1:0] lfa,
                          logic [WORD_W-1:0] wa, logic [BIT_W-1:0] ba);
    if (!no_idle && $urandom_range(0, 7) == 0) begin
      cmd_if.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    cmd_if.valid      <= 1'b1;
    cmd_if.command    <= cmd;
    cmd_if.frame_addr <= lfa;
    cmd_if.word_addr  <= wa;
    cmd_if.bit_addr   <= ba;
    do @(posedge clk); while (!cmd_if.ready);
  endtask

  task automatic wait_drained();
    cmd_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_beats != 0) @(posedge clk);
  endtask

  // both registers, back to back, while the block is idle
  task automatic set_config(int unsigned limit, int unsigned last_word);
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_FRAME_LIMIT;
    cfg_wdata <= CFG_W'(limit);
    @(posedge clk);
    cfg_idx   <= REG_LAST_WORD;
    cfg_wdata <= CFG_W'(last_word);
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_limit     = limit;
    cur_last_word = last_word;
  endtask

  task automatic send_random_cmd();
    logic [CMD_W-1:0]   cmd;
    logic [FRAME_W-1:0] lfa;
    int unsigned        pick;
    int unsigned        lo;
    int unsigned        hi;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      cmd = CMD_W'($urandom_range(0, 7));
    end else if (pick < 45) begin
      cmd = CMD_QUERY;
    end else begin
      cmd = CMD_INJECT;
    end
    // valid frames lie strictly between two thirds of the limit and limit-1
    lo = cur_limit / 3 * 2 + 1;
    hi = (cur_limit >= 2) ? cur_limit - 2 : 0;
    if (lo <= hi && $urandom_range(0, 9) < 8) begin
      case ($urandom_range(0, 15))
        0:       lfa = FRAME_W'(lo);
        1:       lfa = FRAME_W'(hi);
        2:       lfa = FRAME_W'(lo - 1);
        3:       lfa = FRAME_W'(hi + 1);
        default: lfa = FRAME_W'($urandom_range(hi, lo));
      endcase
    end else begin
      lfa = FRAME_W'($urandom);
    end
    send_cmd(cmd, lfa,
             ($urandom_range(0, 7) != 0) ? WORD_W'($urandom_range(0, cur_last_word))
                                         : WORD_W'($urandom),
             ($urandom_range(0, 7) != 0) ? BIT_W'($urandom_range(0, 31)) : BIT_W'($urandom));
  endtask

  initial begin
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_idx           = REG_FRAME_LIMIT;
    cfg_wdata         = '0;
    cmd_if.valid      = 1'b0;
    cmd_if.command    = CMD_IDLE;
    cmd_if.frame_addr = '0;
    cmd_if.word_addr  = '0;
    cmd_if.bit_addr   = '0;
    cur_limit         = FRAME_LIMIT_RST;
    cur_last_word     = LAST_WORD_RST;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: frames 38355..57530 valid, words up to 92
    send_cmd(CMD_IDLE,   20'd0,       8'd0,   8'd0);
    send_cmd(CMD_OBSERV, 20'd0,       8'd0,   8'd0);
    send_cmd(CMD_DETECT, 20'd0,       8'd0,   8'd0);
    send_cmd(CMD_DIAG,   20'd0,       8'd0,   8'd0);
    send_cmd(CMD_SPARE6, 20'd50000,   8'd3,   8'd4);
    send_cmd(CMD_SPARE7, 20'hFFFFF,   8'hFF,  8'hFF);
    send_cmd(CMD_IDLE,   20'hFFFFF,   8'hFF,  8'hFF);
    send_cmd(CMD_QUERY,  20'd38355,   8'hFF,  8'hFF);
    send_cmd(CMD_QUERY,  20'd57530,   8'd5,   8'd7);
    send_cmd(CMD_QUERY,  20'd38354,   8'd0,   8'd0);
    send_cmd(CMD_QUERY,  20'd57531,   8'd0,   8'd0);
    send_cmd(CMD_QUERY,  20'd0,       8'd0,   8'd0);
    send_cmd(CMD_QUERY,  20'hFFFFF,   8'd0,   8'd0);
    send_cmd(CMD_INJECT, 20'd50000,   8'd0,   8'd0);
    send_cmd(CMD_INJECT, 20'd57530,   8'd92,  8'd31);
    send_cmd(CMD_INJECT, 20'd40000,   8'd93,  8'd0);
    send_cmd(CMD_INJECT, 20'd40000,   8'hFF,  8'hFF);
    send_cmd(CMD_INJECT, 20'd40000,   8'd0,   8'd32);
    send_cmd(CMD_INJECT, 20'd40000,   8'd0,   8'hFF);
    send_cmd(CMD_INJECT, 20'd0,       8'hFF,  8'hFF);
    wait_drained();

    // smallest legal limit: no frame is valid
    set_config(3, 0);
    send_cmd(CMD_INJECT, 20'd1,       8'd0,   8'd0);
    send_cmd(CMD_QUERY,  20'd2,       8'd0,   8'd0);
    wait_drained();

    // limits of 0 and 1 reject every frame too
    set_config(1, 0);
    send_cmd(CMD_QUERY,  20'd0,       8'd0,   8'd0);
    wait_drained();
    set_config(0, 0);
    send_cmd(CMD_QUERY,  20'd1,       8'd0,   8'd0);
    wait_drained();

    // largest limit and word index
    set_config(20'hFFFFF, 255);
    send_cmd(CMD_INJECT, 20'hFFFFD,   8'hFF,  8'd31);
    send_cmd(CMD_QUERY,  20'd699051,  8'd0,   8'd0);
    wait_drained();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       set_config($urandom_range(3, 64), $urandom_range(0, 255));
        1:       set_config(20'hFFFFF, 255);
        default: set_config($urandom_range(3, 20'hFFFFF), $urandom_range(0, 255));
      endcase
      if (ph == 1) begin
        holdoff_req++;
      end
      if (ph == PHASES - 1) begin
        no_idle = 1'b1;
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_random_cmd();
      end
      wait_drained();
    end

    repeat (4 * FRAME_BYTES_DEF) @(posedge clk);
    if (fail_count == 0 && pending_beats == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
